// ===== rtl/wavp_pkg.sv =====
// Shared types and constants for the WAVE PCM16 stream parser.
`timescale 1ns / 1ps

package wavp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
	localparam logic [31:0] RIFF_HDR_LEN = 32'd12;
	localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
	localparam logic [15:0] FORMAT_PCM   = 16'd1;
	localparam logic [15:0] BITS_PCM16   = 16'd16;

	typedef enum logic [2:0] {
		PH_RIFF = 3'd0,
		PH_HDR  = 3'd1,
		PH_BODY = 3'd2,
		PH_PAD  = 3'd3,
		PH_ERR  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_WAVE    = 3'd1,
		ST_TRUNCATED   = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_MISSING     = 3'd4
	} status_t;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	typedef struct packed {
		logic [30:0]  sample_total;
		logic [31:0]  rate_hz;
		logic [15:0]  channel_count;
		status_t      status;
		logic         chunk_first;
		logic [15:0]  sample_value;
		kind_t        item_kind;
		logic         final_flag;
	} item_t;

	// Up to two results leave the parser per input beat: a sample, then a report.
	typedef struct packed {
		logic  smp_valid;
		item_t smp;
		logic  rpt_valid;
		item_t rpt;
	} res_pair_t;

endpackage

// ===== rtl/wavp_parse.sv =====
// Input register, chunk walker state and per-byte result logic.
`timescale 1ns / 1ps

module wavp_parse
	import wavp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output res_pair_t  res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	phase_t      phase_q;
	logic [31:0] pos_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [15:0] fmt_q;
	logic [15:0] bits_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic        fvalid_q;
	logic        dseen_q;
	logic [31:0] dlen_q;
	logic [7:0]  low_q;
	status_t     err_q;

	phase_t      n_phase;
	logic [31:0] n_pos;
	logic [31:0] n_tag;
	logic [31:0] n_len;
	logic [15:0] n_fmt;
	logic [15:0] n_bits;
	logic [15:0] n_chan;
	logic [31:0] n_rate;
	logic        n_fvalid;
	logic        n_dseen;
	logic [31:0] n_dlen;
	logic [7:0]  n_low;
	status_t     n_err;

	logic        fin_req;
	logic        fail_req;
	status_t     fail_code;
	logic [31:0] pos_inc;
	logic [31:0] tag_sh;
	logic [31:0] len_sh;
	status_t     rpt_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign pos_inc = pos_q + 32'd1;
	assign tag_sh  = {byte_s1, tag_q[31:8]};
	assign len_sh  = {byte_s1, len_q[31:8]};

	always_comb begin
		n_phase   = phase_q;
		n_pos     = pos_q;
		n_tag     = tag_q;
		n_len     = len_q;
		n_fmt     = fmt_q;
		n_bits    = bits_q;
		n_chan    = chan_q;
		n_rate    = rate_q;
		n_fvalid  = fvalid_q;
		n_dseen   = dseen_q;
		n_dlen    = dlen_q;
		n_low     = low_q;
		n_err     = err_q;
		fin_req   = 1'b0;
		fail_req  = 1'b0;
		fail_code = ST_OK;
		res.smp_valid = 1'b0;
		res.smp       = '0;

		case (phase_q)
			PH_RIFF: begin
				n_tag = tag_sh;
				if (pos_q == 32'd3 && tag_sh != TAG_RIFF) begin
					fail_req  = 1'b1;
					fail_code = ST_NOT_WAVE;
				end else if (pos_q == RIFF_HDR_LEN - 32'd1) begin
					if (tag_sh != TAG_WAVE) begin
						fail_req  = 1'b1;
						fail_code = ST_NOT_WAVE;
					end else begin
						n_phase = PH_HDR;
						n_pos   = '0;
					end
				end else begin
					n_pos = pos_inc;
					if (last_s1) begin
						fail_req  = 1'b1;
						fail_code = ST_NOT_WAVE;
					end
				end
			end
			PH_HDR: begin
				if (pos_q < 32'd4) begin
					n_tag = tag_sh;
				end else begin
					n_len = len_sh;
				end
				if (pos_inc == CHUNK_HDR_LEN) begin
					n_pos = '0;
					if (n_tag == TAG_DATA) begin
						n_dseen = 1'b1;
						n_dlen  = n_len;
					end
					if (n_len == 32'd0) begin
						fin_req = 1'b1;
					end else begin
						n_phase = PH_BODY;
						if (last_s1) begin
							fail_req  = 1'b1;
							fail_code = ST_TRUNCATED;
						end
					end
				end else begin
					n_pos = pos_inc;
				end
			end
			PH_BODY: begin
				if (tag_q == TAG_FMT) begin
					if (pos_q < 32'd2) begin
						if (pos_q[0]) n_fmt[15:8] = byte_s1;
						else          n_fmt[7:0]  = byte_s1;
					end else if (pos_q < 32'd4) begin
						if (pos_q[0]) n_chan[15:8] = byte_s1;
						else          n_chan[7:0]  = byte_s1;
					end else if (pos_q < 32'd8) begin
						case (pos_q[1:0])
							2'd0:    n_rate[7:0]   = byte_s1;
							2'd1:    n_rate[15:8]  = byte_s1;
							2'd2:    n_rate[23:16] = byte_s1;
							default: n_rate[31:24] = byte_s1;
						endcase
					end else if (pos_q == 32'd14) begin
						n_bits[7:0] = byte_s1;
					end else if (pos_q == 32'd15) begin
						n_bits[15:8] = byte_s1;
					end
				end else if (tag_q == TAG_DATA) begin
					if (pos_q[0]) begin
						res.smp_valid        = 1'b1;
						res.smp.item_kind    = KIND_SAMPLE;
						res.smp.sample_value = {byte_s1, low_q};
						res.smp.chunk_first  = (pos_q == 32'd1);
						res.smp.status       = ST_OK;
					end else begin
						n_low = byte_s1;
					end
				end
				if (pos_inc == len_q) begin
					fin_req = 1'b1;
				end else begin
					n_pos = pos_inc;
					if (last_s1) begin
						fail_req  = 1'b1;
						fail_code = ST_TRUNCATED;
					end
				end
			end
			PH_PAD: begin
				n_phase = PH_HDR;
				n_pos   = '0;
			end
			default: begin
			end
		endcase

		// End of a chunk: validate fmt, then skip the pad byte after an odd body.
		if (fin_req) begin
			if (n_tag == TAG_FMT &&
			    (n_len < FMT_MIN_LEN || n_fmt != FORMAT_PCM || n_bits != BITS_PCM16)) begin
				fail_req  = 1'b1;
				fail_code = ST_UNSUPPORTED;
			end else begin
				if (n_tag == TAG_FMT) begin
					n_fvalid = (n_chan != 16'd0) && (n_rate != 32'd0);
				end
				n_phase = n_len[0] ? PH_PAD : PH_HDR;
				n_pos   = '0;
			end
		end

		if (fail_req) begin
			n_err   = fail_code;
			n_phase = PH_ERR;
		end

		rpt_status = n_err;
		if (n_err == ST_OK && (!n_fvalid || !n_dseen || n_dlen[0])) begin
			rpt_status = ST_MISSING;
		end

		res.smp_valid = res.smp_valid & valid_s1;
		res.rpt_valid = valid_s1 & last_s1;
		res.rpt            = '0;
		res.rpt.item_kind  = KIND_REPORT;
		res.rpt.final_flag = 1'b1;
		res.rpt.status     = rpt_status;
		if (rpt_status == ST_OK) begin
			res.rpt.channel_count = n_chan;
			res.rpt.rate_hz       = n_rate;
			res.rpt.sample_total  = n_dlen[31:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF;
			pos_q    <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			fmt_q    <= '0;
			bits_q   <= '0;
			chan_q   <= '0;
			rate_q   <= '0;
			fvalid_q <= 1'b0;
			dseen_q  <= 1'b0;
			dlen_q   <= '0;
			low_q    <= '0;
			err_q    <= ST_OK;
		end else if (valid_s1) begin
			if (last_s1) begin
				// Report goes out this beat; start clean for the next file.
				phase_q  <= PH_RIFF;
				pos_q    <= '0;
				tag_q    <= '0;
				len_q    <= '0;
				fmt_q    <= '0;
				bits_q   <= '0;
				chan_q   <= '0;
				rate_q   <= '0;
				fvalid_q <= 1'b0;
				dseen_q  <= 1'b0;
				dlen_q   <= '0;
				low_q    <= '0;
				err_q    <= ST_OK;
			end else begin
				phase_q  <= n_phase;
				pos_q    <= n_pos;
				tag_q    <= n_tag;
				len_q    <= n_len;
				fmt_q    <= n_fmt;
				bits_q   <= n_bits;
				chan_q   <= n_chan;
				rate_q   <= n_rate;
				fvalid_q <= n_fvalid;
				dseen_q  <= n_dseen;
				dlen_q   <= n_dlen;
				low_q    <= n_low;
				err_q    <= n_err;
			end
		end
	end

endmodule

// ===== rtl/wavp_out_fifo.sv =====
// Result queue: takes up to two items per cycle, hands out one per beat.
`timescale 1ns / 1ps

module wavp_out_fifo
	import wavp_pkg::*;
#(
	parameter int unsigned Depth = 8
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_pair_t res,
	output logic      space_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output item_t     out_item
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = PtrW + 1;
	// Room for the beat in the input register plus the one being accepted.
	localparam logic [CntW-1:0] AcceptMax = CntW'(Depth - 4);

	item_t           mem [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;

	item_t           wr_a;
	logic [1:0]      n_push;
	logic            pop;
	logic [PtrW-1:0] wr_b;

	assign wr_a   = res.smp_valid ? res.smp : res.rpt;
	assign n_push = {1'b0, res.smp_valid} + {1'b0, res.rpt_valid};
	assign wr_b   = wr_q + PtrW'(1);
	assign pop    = out_valid & out_ready;

	assign out_valid = (cnt_q != '0);
	assign out_item  = mem[rd_q];
	assign space_ok  = (cnt_q <= AcceptMax);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem[wr_q] <= wr_a;
		end
		if (n_push == 2'd2) begin
			mem[wr_b] <= res.rpt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PtrW'(n_push);
			if (pop) begin
				rd_q <= rd_q + PtrW'(1);
			end
			cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
		end
	end

endmodule

// ===== rtl/wav_pcm16_stream_parser.sv =====
// Top level of the RIFF/WAVE PCM16 stream parser.
`timescale 1ns / 1ps

// Takes one byte of a WAVE file per beat on s_axis (tlast on the final byte) and
// emits one beat per 16-bit sample of each data chunk on m_axis, tuser[1] set on
// the first sample of a chunk, then a report beat (tlast, tuser[0]) with status,
// channel count, sample rate and sample count of the last data chunk. Keep the
// last marked run and drop it all if the report status is nonzero. A byte is
// accepted every cycle while the result queue (FifoDepth entries, a power of two,
// at least 8) holds at most FifoDepth-4 items; the results of a byte pass through the
// input register and then the result queue on their way to the output.
// After the report the block returns to its reset state, ready for the next file.

module wav_pcm16_stream_parser
	import wavp_pkg::*;
#(
	parameter int unsigned FifoDepth = 8
)
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] sample_value, [18:16] status, [34:19] channel_count,
	// [66:35] rate_hz, [97:67] sample_total, [103:98] zero
	output logic [103:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // [0] item_kind, [1] chunk_first
	output logic         m_axis_tlast    // final_flag
);

	res_pair_t res;
	item_t     out_item;
	logic      space_ok;

	assign s_axis_tready = space_ok;

	wavp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid & s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.res      (res)
	);

	wavp_out_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.space_ok  (space_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {6'd0, out_item.sample_total, out_item.rate_hz,
	                       out_item.channel_count, out_item.status,
	                       out_item.sample_value};
	assign m_axis_tuser = {out_item.chunk_first, out_item.item_kind};
	assign m_axis_tlast = out_item.final_flag;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the RIFF/WAVE PCM16 stream parser.
`timescale 1ns / 1ps

module tb_top;
	import wavp_pkg::*;

	localparam logic [31:0] TAG_LIST = 32'h5453_494C;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] sample;
		logic        first;
		status_t     st;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [30:0] total;
		logic        fin;
	} wav_item_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // [7:0] data_byte
	logic         s_axis_tlast;   // last_byte
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [15:0] sample_value, [18:16] status, [34:19] channel_count,
	// [66:35] rate_hz, [97:67] sample_total, [103:98] zero
	logic [103:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;   // [0] item_kind, [1] chunk_first
	logic         m_axis_tlast;   // final_flag

	wav_pcm16_stream_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// parser shadow state
	phase_t      ph;
	logic [31:0] pos;
	logic [31:0] tag;
	logic [31:0] clen;
	logic [15:0] fmt_code;
	logic [15:0] bits;
	logic [15:0] chans;
	logic [31:0] rate;
	logic        fmt_ok;
	logic        data_seen;
	logic [31:0] data_len;
	logic [7:0]  low_byte;
	status_t     err;

	wav_item_t   expected_items[$];
	logic [7:0]  file_bytes[$];
	int unsigned mismatches;
	int unsigned bytes_sent;
	logic        no_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void clear_parser();
		ph        = PH_RIFF;
		pos       = '0;
		tag       = '0;
		clen      = '0;
		fmt_code  = '0;
		bits      = '0;
		chans     = '0;
		rate      = '0;
		fmt_ok    = 1'b0;
		data_seen = 1'b0;
		data_len  = '0;
		low_byte  = '0;
		err       = ST_OK;
	endfunction

	function automatic void abort_file(input status_t code);
		err = code;
		ph  = PH_ERR;
	endfunction

	function automatic void close_chunk();
		if (tag == TAG_FMT) begin
			if (clen < FMT_MIN_LEN || fmt_code != FORMAT_PCM || bits != BITS_PCM16) begin
				abort_file(ST_UNSUPPORTED);
				return;
			end
			fmt_ok = (chans != 16'd0) && (rate != 32'd0);
		end
		ph  = clen[0] ? PH_PAD : PH_HDR;
		pos = '0;
	endfunction

	// Advance the shadow parser by one accepted byte and queue what it yields.
	function automatic void parse_byte(input logic [7:0] b, input logic is_last);
		wav_item_t it;
		it = '0;
		case (ph)
			PH_RIFF: begin
				tag = {b, tag[31:8]};
				if (pos == 32'd3 && tag != TAG_RIFF) begin
					abort_file(ST_NOT_WAVE);
				end else if (pos == RIFF_HDR_LEN - 1) begin
					if (tag != TAG_WAVE) begin
						abort_file(ST_NOT_WAVE);
					end else begin
						ph  = PH_HDR;
						pos = '0;
					end
				end else begin
					pos++;
					if (is_last)
						abort_file(ST_NOT_WAVE);
				end
			end
			PH_HDR: begin
				if (pos < 32'd4)
					tag = {b, tag[31:8]};
				else
					clen = {b, clen[31:8]};
				pos++;
				if (pos == CHUNK_HDR_LEN) begin
					pos = '0;
					if (tag == TAG_DATA) begin
						data_seen = 1'b1;
						data_len  = clen;
					end
					if (clen == 32'd0) begin
						close_chunk();
					end else begin
						ph = PH_BODY;
						if (is_last)
							abort_file(ST_TRUNCATED);
					end
				end
			end
			PH_BODY: begin
				if (tag == TAG_FMT) begin
					if (pos < 32'd2)
						fmt_code[{pos[0], 3'b000} +: 8] = b;
					else if (pos < 32'd4)
						chans[{pos[0], 3'b000} +: 8] = b;
					else if (pos < 32'd8)
						rate[{pos[1:0], 3'b000} +: 8] = b;
					else if (pos == 32'd14 || pos == 32'd15)
						bits[{pos[0], 3'b000} +: 8] = b;
				end else if (tag == TAG_DATA) begin
					if (pos[0]) begin
						it.kind   = KIND_SAMPLE;
						it.sample = {b, low_byte};
						it.first  = (pos == 32'd1);
						it.st     = ST_OK;
						expected_items.push_back(it);
					end else begin
						low_byte = b;
					end
				end
				pos++;
				if (pos == clen)
					close_chunk();
				else if (is_last)
					abort_file(ST_TRUNCATED);
			end
			PH_PAD: begin
				ph  = PH_HDR;
				pos = '0;
			end
			default: begin
			end
		endcase
		if (is_last) begin
			it      = '0;
			it.kind = KIND_REPORT;
			it.fin  = 1'b1;
			it.st   = err;
			if (err == ST_OK && (!fmt_ok || !data_seen || data_len[0]))
				it.st = ST_MISSING;
			if (it.st == ST_OK) begin
				it.chans = chans;
				it.rate  = rate;
				it.total = data_len[31:1];
			end
			expected_items.push_back(it);
			clear_parser();
		end
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		wav_item_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_items.size() == 0) begin
				flag_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
			end else begin
				want = expected_items.pop_front();
				if (m_axis_tuser[0] !== want.kind)
					flag_mismatch("item_kind", 32'(m_axis_tuser[0]), 32'(want.kind));
				if (m_axis_tdata[15:0] !== want.sample)
					flag_mismatch("sample_value", 32'(m_axis_tdata[15:0]),
						32'(want.sample));
				if (m_axis_tuser[1] !== want.first)
					flag_mismatch("chunk_first", 32'(m_axis_tuser[1]), 32'(want.first));
				if (m_axis_tdata[18:16] !== want.st)
					flag_mismatch("status", 32'(m_axis_tdata[18:16]), 32'(want.st));
				if (m_axis_tdata[34:19] !== want.chans)
					flag_mismatch("channel_count", 32'(m_axis_tdata[34:19]),
						32'(want.chans));
				if (m_axis_tdata[66:35] !== want.rate)
					flag_mismatch("rate_hz", m_axis_tdata[66:35], want.rate);
				if (m_axis_tdata[97:67] !== want.total)
					flag_mismatch("sample_total", 32'(m_axis_tdata[97:67]),
						32'(want.total));
				if (m_axis_tlast !== want.fin)
					flag_mismatch("final_flag", 32'(m_axis_tlast), 32'(want.fin));
			end
		end
	end

	always @(posedge clk)
		m_axis_tready <= no_idle || ($urandom_range(99) >= 15);

	// Drive one byte and hold it until the parser takes it.
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		while (!no_idle && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		parse_byte(value, is_last);
	endtask

	task automatic send_file();
		int unsigned n;
		n = file_bytes.size();
		for (int unsigned i = 0; i < n; i++)
			send_byte(file_bytes[i], i == n - 1);
		file_bytes.delete();
		bytes_sent += n;
	endtask

	function automatic void put_le(input logic [31:0] value, input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			file_bytes.push_back(value[8 * i +: 8]);
	endfunction

	function automatic void put_riff_head(input logic [31:0] riff, input logic [31:0] form);
		put_le(riff, 4);
		put_le($urandom, 4);
		put_le(form, 4);
	endfunction

	function automatic void put_chunk(input logic [31:0] ctag, input int unsigned len);
		put_le(ctag, 4);
		put_le(len, 4);
		repeat (len) put_le($urandom, 1);
		if (len % 2)
			put_le($urandom, 1);
	endfunction

	function automatic void put_fmt(input logic [15:0] code, input logic [15:0] nch,
			input logic [31:0] hz, input logic [15:0] depth, input int unsigned len);
		logic [127:0] fields;
		fields = {depth, 16'($urandom), 32'($urandom), hz, nch, code};
		put_le(TAG_FMT, 4);
		put_le(len, 4);
		for (int unsigned i = 0; i < len; i++)
			put_le(i < 16 ? fields[8 * i +: 8] : 8'($urandom), 1);
		if (len % 2)
			put_le($urandom, 1);
	endfunction

	function automatic void put_random_fmt();
		logic [15:0] code;
		logic [15:0] nch;
		logic [15:0] depth;
		logic [31:0] hz;
		int unsigned len;
		int unsigned pick;
		pick  = $urandom_range(99);
		code  = pick < 4 ? 16'($urandom_range(0, 3)) : FORMAT_PCM;
		depth = (pick >= 4 && pick < 8) ? 16'($urandom_range(8, 32)) : BITS_PCM16;
		if (pick >= 8 && pick < 11)
			nch = 16'd0;
		else
			nch = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 8));
		hz    = (pick >= 11 && pick < 14) ? 32'd0 : 32'($urandom);
		if (pick >= 14 && pick < 17)
			len = $urandom_range(0, 15);
		else
			len = $urandom_range(3) == 0 ? $urandom_range(16, 19) : 16;
		put_fmt(code, nch, hz, depth, len);
	endfunction

	task automatic build_random_file();
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		pick = $urandom_range(99);
		if (pick < 4) begin
			repeat ($urandom_range(1, 24)) put_le($urandom, 1);
			return;
		end
		put_riff_head(pick < 7 ? TAG_RIFF ^ (32'h1 << $urandom_range(31)) : TAG_RIFF,
			(pick >= 7 && pick < 10) ? TAG_WAVE ^ (32'h1 << $urandom_range(31)) : TAG_WAVE);
		if ($urandom_range(99) < 85)
			put_random_fmt();
		repeat ($urandom_range(1, 3)) begin
			pick = $urandom_range(9);
			if (pick < 2) begin
				put_random_fmt();
			end else if (pick < 7) begin
				len = $urandom_range(99) < 10 ? $urandom_range(0, 60) : 2 * $urandom_range(0, 12);
				put_chunk(TAG_DATA, len);
			end else begin
				put_chunk($urandom_range(1) ? TAG_LIST : 32'($urandom), $urandom_range(0, 9));
			end
		end
		// cut the tail now and then to land the flag mid-chunk
		if ($urandom_range(99) < 12 && file_bytes.size() > 1) begin
			cut = $urandom_range(1, file_bytes.size() > 10 ? 10 : file_bytes.size() - 1);
			repeat (cut) void'(file_bytes.pop_back());
		end
	endtask

	task automatic test_short_headers();
		put_le(8'h52, 1);
		send_file();
		put_le(TAG_RIFF, 3);
		send_file();
		put_le(32'h5846_4952, 4);
		put_le(32'd36, 4);
		send_file();
		put_riff_head(TAG_RIFF, 32'h4556_4158);
		send_file();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		void'(file_bytes.pop_back());
		send_file();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		send_file();
	endtask

	task automatic test_basic_files();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, BITS_PCM16, 16);
		put_le(TAG_DATA, 4);
		put_le(32'd8, 4);
		put_le(32'h7FFF_8000, 4);
		put_le(32'hFFFF_0000, 4);
		send_file();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd1, 32'd1, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 2);
		send_file();
	endtask

	task automatic send_fmt_case(input logic [15:0] code, input logic [15:0] nch,
			input logic [31:0] hz, input logic [15:0] depth, input int unsigned len);
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(code, nch, hz, depth, len);
		put_chunk(TAG_DATA, 4);
		send_file();
	endtask

	task automatic test_fmt_checks();
		send_fmt_case(FORMAT_PCM, 16'd2, 32'd44100, BITS_PCM16, 14);
		send_fmt_case(16'd3, 16'd2, 32'd44100, BITS_PCM16, 16);
		send_fmt_case(FORMAT_PCM, 16'd2, 32'd44100, 16'd24, 16);
		send_fmt_case(FORMAT_PCM, 16'd0, 32'd44100, BITS_PCM16, 16);
		send_fmt_case(FORMAT_PCM, 16'd2, 32'd0, BITS_PCM16, 16);
		send_fmt_case(FORMAT_PCM, 16'd6, 32'd96000, BITS_PCM16, 17);
		send_fmt_case(FORMAT_PCM, 16'd2, 32'd8000, BITS_PCM16, 0);
	endtask

	task automatic test_chunk_walk();
		// odd unknown chunk with pad, then an empty data chunk
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_chunk(TAG_LIST, 3);
		put_fmt(FORMAT_PCM, 16'd2, 32'd48000, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 0);
		send_file();
		// only the last data chunk counts
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd2, 32'd48000, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 6);
		put_chunk(TAG_LIST, 5);
		put_chunk(TAG_DATA, 4);
		send_file();
		// odd data length
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd1, 32'd22050, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 5);
		send_file();
		// data before fmt, trailing chunk without its pad
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_chunk(TAG_DATA, 4);
		put_fmt(FORMAT_PCM, 16'd1, 32'd11025, BITS_PCM16, 16);
		put_chunk(TAG_LIST, 3);
		void'(file_bytes.pop_back());
		send_file();
		// partial chunk header at the end
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd2, 32'd32000, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 4);
		put_le(TAG_DATA, 4);
		put_le(32'd2, 1);
		send_file();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd2, 32'd32000, BITS_PCM16, 16);
		put_chunk(TAG_LIST, 2);
		send_file();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_chunk(TAG_DATA, 4);
		send_file();
	endtask

	task automatic test_truncation();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd2, 32'd44100, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 8);
		repeat (3) void'(file_bytes.pop_back());
		send_file();
		// flag on a header that announces a body
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd2, 32'd44100, BITS_PCM16, 16);
		put_le(TAG_DATA, 4);
		put_le(32'd4, 4);
		send_file();
		// flag on a header with zero length is fine
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd2, 32'd44100, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 4);
		put_le(TAG_LIST, 4);
		put_le(32'd0, 4);
		send_file();
		// bytes after an unsupported fmt are absorbed
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(16'd2, 16'd2, 32'd44100, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 6);
		send_file();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_le(TAG_FMT, 4);
		put_le(32'hFFFF_FFFF, 4);
		repeat (20) put_le($urandom, 1);
		send_file();
	endtask

	task automatic test_drain_pause();
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd2, 32'd44100, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 10);
		send_file();
		// hold off until every result of that file is out
		s_axis_tvalid <= 1'b0;
		while (expected_items.size() != 0) @(posedge clk);
		put_riff_head(TAG_RIFF, TAG_WAVE);
		put_fmt(FORMAT_PCM, 16'd1, 32'd16000, BITS_PCM16, 16);
		put_chunk(TAG_DATA, 6);
		send_file();
	endtask

	task automatic test_back_to_back();
		int unsigned target;
		target  = bytes_sent + 100;
		no_idle = 1'b1;
		while (bytes_sent < target) begin
			build_random_file();
			send_file();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_files();
		int unsigned target;
		target = bytes_sent + 40;
		while (bytes_sent < target) begin
			build_random_file();
			send_file();
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		m_axis_tready <= 1'b0;
		no_idle       = 1'b0;
		mismatches    = 0;
		bytes_sent    = 0;
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_headers();
		test_basic_files();
		test_fmt_checks();
		test_chunk_walk();
		test_truncation();
		test_drain_pause();
		test_back_to_back();
		test_random_files();
		s_axis_tvalid <= 1'b0;
		while (expected_items.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
